// ----- sv/cfp_pkg.sv -----
package cfp_pkg;

    localparam int REPLY_BYTES = 5;
    localparam int IDX_W = $clog2(REPLY_BYTES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_BYTES - 1);
    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(REPLY_BYTES);

    localparam logic [7:0] CMD_READ_LAST = 8'hFA;
    localparam logic [7:0] CMD_READ_FIRST = 8'h10;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam logic [31:0] BYTE_SCALE = 32'd100;
    localparam logic [31:0] DIGIT_SCALE = 32'd10;

    localparam logic [15:0] POLL_INTERVAL_RST = 16'd500;
    localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd2000;
    localparam logic MODEL_KIND_RST = 1'b0;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0] REG_REPLY_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MODEL_KIND = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [31:0] frequency;
        logic        freq_updated;
        logic        connected;
        logic        waiting;
    } result_t;

    typedef struct packed {
        logic [15:0] poll_interval;
        logic [15:0] reply_timeout;
        logic        model_kind;
    } cfg_t;

    typedef logic [REPLY_BYTES-1:0][7:0] store_t;

    typedef struct packed {
        logic   polled;
        logic   model;
        logic   updated;
        logic   connected;
        logic   waiting;
        store_t store;
    } entry_t;

endpackage

// ----- sv/cfp_front.sv -----
module cfp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  cfp_pkg::cfg_t   cfg,
    input  logic            accept,
    input  cfp_pkg::in_t    item,
    output cfp_pkg::entry_t entry
);
    import cfp_pkg::*;

    logic [31:0]      time_now_reg, time_now_next;
    logic [31:0]      last_poll_reg, last_poll_next;
    logic [31:0]      last_reply_reg, last_reply_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             wait_reg, wait_next;
    store_t           store_reg, store_next;

    logic [IDX_W-1:0] count_wr;
    logic             wr;
    logic             polled;
    logic             wait_poll;
    logic             updated;
    logic             timed_out;
    logic [31:0]      poll_age;
    logic [31:0]      wait_age;
    logic [31:0]      reply_age;

    always_comb
    begin
        time_now_next = (item.func == FUNC_TICK) ? time_now_reg + 32'd1 : time_now_reg;
        wr = (item.func == FUNC_BYTE) && (count_reg < FULL_COUNT);
        store_next = store_reg;
        for (int i = 0; i < REPLY_BYTES; i++)
        begin
            if (wr && (count_reg == IDX_W'(i)))
            begin
                store_next[i] = item.rx_byte;
            end
        end
        count_wr = wr ? count_reg + IDX_W'(1) : count_reg;

        poll_age = time_now_next - last_poll_reg;
        polled = poll_age >= {16'd0, cfg.poll_interval};
        last_poll_next = polled ? time_now_next : last_poll_reg;
        wait_poll = polled || wait_reg;

        updated = wait_poll && (count_wr >= FULL_COUNT);
        count_next = updated ? '0 : count_wr;
        last_reply_next = updated ? time_now_next : last_reply_reg;

        wait_age = time_now_next - last_poll_next;
        timed_out = wait_age > {16'd0, cfg.reply_timeout};
        wait_next = wait_poll && !updated && !timed_out;

        reply_age = time_now_next - last_reply_next;

        entry.polled = polled;
        entry.model = cfg.model_kind;
        entry.updated = updated;
        entry.connected = reply_age < {16'd0, cfg.reply_timeout};
        entry.waiting = wait_next;
        entry.store = store_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg <= '0;
            last_poll_reg <= '0;
            last_reply_reg <= '0;
            count_reg <= '0;
            wait_reg <= 1'b0;
        end
        else if (accept)
        begin
            time_now_reg <= time_now_next;
            last_poll_reg <= last_poll_next;
            last_reply_reg <= last_reply_next;
            count_reg <= count_next;
            wait_reg <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= store_next;
        end
    end

endmodule

// ----- sv/cfp_queue.sv -----
module cfp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfp_pkg::entry_t wdata,
    output logic            full,
    input  logic            pop,
    output cfp_pkg::entry_t rdata,
    output logic            empty
);
    import cfp_pkg::*;

    entry_t     mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/cfp_back.sv -----
module cfp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cfp_pkg::entry_t  q_data,
    input  logic             q_empty,
    output logic             q_pop,
    output cfp_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);
    import cfp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_FINAL,
        S_EMIT
    } state_t;

    state_t           state_reg;
    entry_t           ent_reg;
    logic [IDX_W-1:0] step_reg;
    logic [31:0]      acc_reg;
    logic [31:0]      freq_reg;
    result_t          out_reg;
    logic             out_valid_reg;

    logic [IDX_W-1:0] idx;
    logic [7:0]       b;
    logic [7:0]       digit;
    logic [31:0]      acc_next;
    logic [31:0]      freq_next;
    logic             out_free;
    logic             load_out;
    logic             last_out;
    result_t          emit;

    assign q_pop = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || pop;
    assign load_out = (state_reg == S_EMIT) && out_free;
    assign result = out_reg;
    assign empty = !out_valid_reg;

    always_comb
    begin
        idx = ent_reg.model ? LAST_IDX - step_reg : step_reg;
        b = ent_reg.store[idx];
        digit = 8'(b[7:4] & NIBBLE_MASK) * 8'(DIGIT_SCALE) + 8'(b[3:0] & NIBBLE_MASK);
        acc_next = acc_reg * BYTE_SCALE + {24'd0, digit};
        freq_next = ent_reg.model ? acc_reg : acc_reg * DIGIT_SCALE;

        last_out = ent_reg.polled ? (step_reg == LAST_IDX) : 1'b1;
        emit.tx_valid = ent_reg.polled;
        emit.tx_byte = 8'd0;
        if (ent_reg.polled)
        begin
            if (ent_reg.model && (step_reg == '0))
            begin
                emit.tx_byte = CMD_READ_FIRST;
            end
            else if (!ent_reg.model && (step_reg == LAST_IDX))
            begin
                emit.tx_byte = CMD_READ_LAST;
            end
        end
        emit.tx_last = last_out;
        emit.frequency = freq_reg;
        emit.freq_updated = ent_reg.updated;
        emit.connected = ent_reg.connected;
        emit.waiting = ent_reg.waiting;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ent_reg <= '0;
            step_reg <= '0;
            acc_reg <= '0;
            freq_reg <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        ent_reg <= q_data;
                        step_reg <= '0;
                        acc_reg <= '0;
                        state_reg <= q_data.updated ? S_DECODE : S_EMIT;
                    end
                end
                S_DECODE:
                begin
                    acc_reg <= acc_next;
                    step_reg <= step_reg + IDX_W'(1);
                    if (step_reg == LAST_IDX)
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    freq_reg <= freq_next;
                    step_reg <= '0;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg <= emit;
                        step_reg <= step_reg + IDX_W'(1);
                        if (last_out)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/cat_frequency_poller.sv -----
// channel   direction  transfer when         payload
// item      in         push && !full         func, rx_byte
// result    out        pop && !empty         tx_valid .. waiting
// config    in         psel&&penable&&pwrite poll_interval, reply_timeout, model_kind
//
// an item is classified in the cycle it is taken; a two-entry queue holds it for the back end
// the back end loads an entry; when a reply is decoded it then takes one byte
// per cycle through the multiply by 100, then the final scale (times 10 when model_kind is 0)
// it emits a result whenever its output register is free; a poll gives 5 results, any other item 1
// reset clears timers, counters, wait flag and frequency; the reply bytes are not cleared
// a stalled result stays on the ports; items keep coming until the queue fills
module cat_frequency_poller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  cfp_pkg::in_t               item,
    input  logic                       pop,
    output logic                       empty,
    output cfp_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cfp_pkg::*;

    cfg_t   cfg_reg;
    logic   accept;
    logic   cfg_wr;
    entry_t entry;
    entry_t q_data;
    logic   q_empty;
    logic   q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = push && !full;

    always_comb
    begin
        case (paddr[3:2])
            REG_POLL_INTERVAL: prdata = {16'd0, cfg_reg.poll_interval};
            REG_REPLY_TIMEOUT: prdata = {16'd0, cfg_reg.reply_timeout};
            REG_MODEL_KIND:    prdata = {31'd0, cfg_reg.model_kind};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval <= POLL_INTERVAL_RST;
            cfg_reg.reply_timeout <= REPLY_TIMEOUT_RST;
            cfg_reg.model_kind <= MODEL_KIND_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_POLL_INTERVAL: cfg_reg.poll_interval <= pwdata[15:0];
                REG_REPLY_TIMEOUT: cfg_reg.reply_timeout <= pwdata[15:0];
                REG_MODEL_KIND:    cfg_reg.model_kind <= pwdata[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    cfp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .item   (item),
        .entry  (entry)
    );

    cfp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (entry),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_data),
        .empty (q_empty)
    );

    cfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// ----- sv/cfp_checker.sv -----
module cfp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pop,
    input logic             empty,
    input cfp_pkg::result_t result
);
    import cfp_pkg::*;

    // a result without a command byte is the only one of its transfer group
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.tx_valid |-> result.tx_last)
        else $error("non-command result not marked last");

    // a fresh decode always ends the wait
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.freq_updated |-> !result.waiting)
        else $error("waiting still set after decode");

    // the command bytes of one poll come out without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && result.tx_valid && !result.tx_last |=> !empty && result.tx_valid)
        else $error("gap inside a command");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while stalled");

endmodule

bind cat_frequency_poller cfp_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

// ----- dv/tb_cat_frequency_poller.sv -----
`timescale 1ns / 1ps

module tb_cat_frequency_poller;

    import cfp_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 36;

    class freq_poll_scoreboard;
        cfg_t        cfg;
        logic [31:0] now_ms;
        logic [31:0] poll_ms;
        logic [31:0] reply_ms;
        logic [31:0] freq;
        logic [7:0]  reply_bytes [REPLY_BYTES];
        int          reply_cnt;
        logic        awaiting;
        result_t     expected_results [$];
        int          errors;
        int          n_items;
        int          n_results;
        int          n_polls;
        int          n_decodes;
        int          n_settings;

        function new();
            cfg.poll_interval = POLL_INTERVAL_RST;
            cfg.reply_timeout = REPLY_TIMEOUT_RST;
            cfg.model_kind = MODEL_KIND_RST;
            now_ms = '0;
            poll_ms = '0;
            reply_ms = '0;
            freq = '0;
            reply_cnt = 0;
            awaiting = 1'b0;
            errors = 0;
            n_items = 0;
            n_results = 0;
            n_polls = 0;
            n_decodes = 0;
            n_settings = 1;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_POLL_INTERVAL: cfg.poll_interval = val;
                REG_REPLY_TIMEOUT: cfg.reply_timeout = val;
                REG_MODEL_KIND:    cfg.model_kind = val[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] decode_bcd();
            logic [63:0] acc;
            logic [7:0]  b;
            acc = '0;
            for (int k = 0; k < REPLY_BYTES; k++)
            begin
                b = cfg.model_kind ? reply_bytes[REPLY_BYTES - 1 - k] : reply_bytes[k];
                acc = acc * 64'd100 + 64'(b[7:4]) * 64'd10 + 64'(b[3:0]);
            end
            if (!cfg.model_kind)
                acc = acc * 64'd10;
            return acc[31:0];
        endfunction

        function void note_item(in_t x);
            result_t r;
            logic    polled;
            logic    updated;
            logic    conn;
            int      n;
            polled = 1'b0;
            updated = 1'b0;
            n_items++;
            if (x.func == FUNC_TICK)
                now_ms = now_ms + 32'd1;
            else if (reply_cnt < REPLY_BYTES)
            begin
                reply_bytes[reply_cnt] = x.rx_byte;
                reply_cnt++;
            end
            if (32'(now_ms - poll_ms) >= {16'd0, cfg.poll_interval})
            begin
                polled = 1'b1;
                poll_ms = now_ms;
                awaiting = 1'b1;
                n_polls++;
            end
            if (awaiting)
            begin
                if (reply_cnt >= REPLY_BYTES)
                begin
                    freq = decode_bcd();
                    reply_cnt = 0;
                    reply_ms = now_ms;
                    updated = 1'b1;
                    awaiting = 1'b0;
                    n_decodes++;
                end
                if (32'(now_ms - poll_ms) > {16'd0, cfg.reply_timeout})
                    awaiting = 1'b0;
            end
            conn = 32'(now_ms - reply_ms) < {16'd0, cfg.reply_timeout};
            n = polled ? REPLY_BYTES : 1;
            for (int k = 0; k < n; k++)
            begin
                r.tx_valid = polled;
                r.tx_byte = 8'h00;
                if (polled && cfg.model_kind && k == 0)
                    r.tx_byte = CMD_READ_FIRST;
                if (polled && !cfg.model_kind && k == REPLY_BYTES - 1)
                    r.tx_byte = CMD_READ_LAST;
                r.tx_last = (k == n - 1);
                r.frequency = freq;
                r.freq_updated = updated;
                r.connected = conn;
                r.waiting = awaiting;
                expected_results.push_back(r);
            end
        endfunction

        function string show(result_t r);
            return $sformatf("valid=%0d byte=%02h last=%0d freq=%0d upd=%0d conn=%0d wait=%0d",
                r.tx_valid, r.tx_byte, r.tx_last, r.frequency, r.freq_updated,
                r.connected, r.waiting);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            n_results++;
            if (expected_results.size() == 0)
            begin
                flag($sformatf("unexpected result: %s", show(got)));
                return;
            end
            exp = expected_results.pop_front();
            if (got.tx_valid !== exp.tx_valid || got.tx_byte !== exp.tx_byte
                || got.tx_last !== exp.tx_last || got.frequency !== exp.frequency
                || got.freq_updated !== exp.freq_updated || got.connected !== exp.connected
                || got.waiting !== exp.waiting)
                flag($sformatf("mismatch: exp %s / got %s", show(exp), show(got)));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    in_t                 item = '0;
    logic                pop = 1'b0;
    logic                empty;
    result_t             result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    freq_poll_scoreboard sb = new();
    logic                idle_off = 1'b0;
    int                  pop_stall = 0;
    int                  quiet_cycles = 0;

    cat_frequency_poller i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .pop     (pop),
        .empty   (empty),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // result side with random stall bursts
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
        if (pop_stall > 0)
        begin
            pop_stall--;
            pop <= 1'b0;
        end
        else if (!idle_off && $urandom_range(0, 7) == 0)
        begin
            pop_stall = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                STALL_LIMIT, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic feed(logic f, logic [7:0] b);
        in_t x;
        x.func = f;
        x.rx_byte = b;
        if (!idle_off && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        item <= x;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_item(x);
    endtask

    task automatic feed_ticks(int n);
        repeat (n) feed(FUNC_TICK, 8'($urandom));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        logic [31:0] readback;
        readback = (idx == REG_MODEL_KIND) ? {31'd0, val[0]} : {16'd0, val};
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== readback)
            sb.flag($sformatf("register %0d reads %h, wrote %h", idx, prdata, readback));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [15:0] interval, logic [15:0] tmo, logic model);
        write_reg(REG_POLL_INTERVAL, interval);
        write_reg(REG_REPLY_TIMEOUT, tmo);
        write_reg(REG_MODEL_KIND, {15'd0, model});
        sb.n_settings++;
    endtask

    function automatic logic [7:0] reply_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    task automatic random_phase(int target);
        int          goal;
        int          n;
        int          tmo_ticks;
        logic [15:0] interval;
        logic [15:0] tmo;
        goal = sb.n_items + target;
        interval = sb.cfg.poll_interval;
        tmo = sb.cfg.reply_timeout;
        tmo_ticks = (tmo > 30) ? 30 : int'(tmo) + $urandom_range(1, 4);
        while (sb.n_items < goal)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    // short reply, then ticks that let the wait run out unless the timeout is above 30
                    n = $urandom_range(1, 4);
                    repeat (n) feed(FUNC_BYTE, reply_byte());
                    feed_ticks(tmo_ticks);
                end
                8:
                begin
                    n = $urandom_range(6, 8);
                    repeat (n) feed(FUNC_BYTE, reply_byte());
                end
                9:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) feed(1'($urandom), 8'($urandom));
                end
                default:
                begin
                    feed_ticks($urandom_range(0, int'(interval) + 2));
                    repeat (REPLY_BYTES) feed(FUNC_BYTE, reply_byte());
                end
            endcase
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: connected at start-up, stale bytes held
        feed_ticks(2);
        feed(FUNC_BYTE, 8'h12);
        feed(FUNC_BYTE, 8'h34);
        drain();

        // poll on every step, zero timeout, low-first decode
        configure(16'd0, 16'd0, 1'b1);
        feed(FUNC_TICK, 8'hFF);
        feed(FUNC_BYTE, 8'h56);
        feed(FUNC_BYTE, 8'h78);
        feed(FUNC_BYTE, 8'h90);
        repeat (REPLY_BYTES) feed(FUNC_BYTE, 8'hFF);
        feed(FUNC_TICK, 8'h00);
        drain();

        // no polling: fill the store, drop the extra bytes
        configure(16'hFFFF, 16'hFFFF, 1'b0);
        repeat (REPLY_BYTES) feed(FUNC_BYTE, 8'h99);
        feed(FUNC_BYTE, 8'h00);
        feed(FUNC_BYTE, 8'hA5);
        feed(FUNC_TICK, 8'h5A);
        drain();

        // held bytes decoded at the next poll, which ends the wait
        configure(16'd5, 16'd2, 1'b0);
        feed_ticks(6);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
                idle_off = 1'b1;
            configure((p == 2) ? 16'd0 : 16'($urandom_range(1, 10)),
                (p == 4) ? 16'hFFFF : 16'($urandom_range(0, 25)), p[0]);
            random_phase(PHASE_ITEMS);
            drain();
        end
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
            sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
        $display("covered %0d items and %0d results over %0d register settings",
            sb.n_items, sb.n_results, sb.n_settings);
        $display("%0d polls issued, %0d replies decoded, %0d failures",
            sb.n_polls, sb.n_decodes, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
